// ===== src/brh_pkg.sv =====
package brh_pkg;

  // default sizes, handed to the top level parameters
  localparam int MAX_BINS_DEF    = 256;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // field widths of the external words
  localparam int SAMPLE_W = 16;
  localparam int SEL_W    = 8;
  localparam int CNT_W    = 32;

  // bin index width carried in a job, enough for the largest bin count
  localparam int JOB_BIN_W = 12;
  localparam int COLOURS   = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_BINS_LOG2   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAYER_ORDER = 2'd1;

  localparam logic [3:0] BINS_LOG2_RESET   = 4'd8;
  localparam logic [1:0] BAYER_ORDER_RESET = 2'd0;

  // colour slots of the histogram memories
  localparam int COL_RED     = 0;
  localparam int COL_GREEN_R = 1;
  localparam int COL_GREEN_B = 2;
  localparam int COL_BLUE    = 3;

  // input opcodes; the fourth code is ignored
  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  // work handed from front to back
  typedef enum logic [1:0] {
    JOB_ACCUM = 2'd0,
    JOB_READ  = 2'd1,
    JOB_CLEAR = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                               kind;
    logic [COLOURS-1:0][JOB_BIN_W-1:0]       bin;     // per colour bin address
    logic                                    rd_zero; // read beyond the stores
    logic [SEL_W-1:0]                        sel;
  } job_t;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [SAMPLE_W-1:0] plane_00;
    logic [SAMPLE_W-1:0] plane_01;
    logic [SAMPLE_W-1:0] plane_10;
    logic [SAMPLE_W-1:0] plane_11;
    logic [SEL_W-1:0]    bin_select;
  } in_word_t;

  typedef struct packed {
    logic [SEL_W-1:0] bin_number;
    logic [CNT_W-1:0] red_count;
    logic [CNT_W-1:0] green_r_count;
    logic [CNT_W-1:0] green_b_count;
    logic [CNT_W-1:0] blue_count;
    logic [CNT_W-1:0] cell_total;
  } out_word_t;

endpackage

// ===== src/brh_queue.sv =====
module brh_queue
  import brh_pkg::*;
#(
  parameter int  DEPTH  = QUEUE_DEPTH_DEF,
  parameter type item_t = job_t
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);

  item_t              slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== src/brh_front.sv =====
module brh_front
  import brh_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  in_push,
  input  in_word_t              in_word,
  output logic                  in_full,
  // towards the job queue
  input  logic                  q_full,
  input  logic                  back_busy,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int LG_FLOOR = $clog2(MAX_BINS + 1) - 1;
  localparam int LG_LIM   = (LG_FLOOR < SAMPLE_BITS) ? LG_FLOOR : SAMPLE_BITS;

  logic [3:0]             bins_log2_r;
  logic [1:0]             bayer_order_r;
  logic [3:0]             lg;
  logic [4:0]             shamt;
  logic [SAMPLE_W-1:0]    raw [COLOURS];
  logic [JOB_BIN_W-1:0]   pos_bin [COLOURS];

  assign cfg_ready = 1'b1;
  assign in_full   = q_full || back_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_log2_r   <= BINS_LOG2_RESET;
      bayer_order_r <= BAYER_ORDER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BINS_LOG2:   bins_log2_r   <= cfg_data[3:0];
        REG_BAYER_ORDER: bayer_order_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective bin count and shift
  always_comb begin
    if (bins_log2_r < 4'd1)
      lg = 4'd1;
    else if (bins_log2_r > 4'(LG_LIM))
      lg = 4'(LG_LIM);
    else
      lg = bins_log2_r;
    shamt = 5'(SAMPLE_BITS) - {1'b0, lg};
  end

  // bin of each plane position, saturating over-wide samples
  assign raw[0] = in_word.plane_00;
  assign raw[1] = in_word.plane_01;
  assign raw[2] = in_word.plane_10;
  assign raw[3] = in_word.plane_11;

  always_comb begin
    logic [SAMPLE_BITS-1:0] s_sat;
    logic [SAMPLE_BITS-1:0] shifted;
    for (int p = 0; p < COLOURS; p++) begin
      s_sat = ((raw[p] >> SAMPLE_BITS) != '0) ? '1 : raw[p][SAMPLE_BITS-1:0];
      shifted = s_sat >> shamt;
      pos_bin[p] = JOB_BIN_W'(shifted);
    end
  end

  // classify the word into a job
  always_comb begin
    logic sel_out;
    sel_out       = (int'(in_word.bin_select) >= MAX_BINS);
    q_job         = '0;
    q_job.sel     = in_word.bin_select;
    q_job.rd_zero = sel_out;
    q_push        = 1'b0;
    case (in_word.opcode)
      OP_ACCUM: begin
        q_job.kind = JOB_ACCUM;
        q_push     = in_push && !in_full;
        // colour c sits at position c xor order
        for (int c = 0; c < COLOURS; c++)
          q_job.bin[c] = pos_bin[2'(c) ^ bayer_order_r];
      end
      OP_READ: begin
        q_job.kind = JOB_READ;
        q_push     = in_push && !in_full;
        for (int c = 0; c < COLOURS; c++)
          q_job.bin[c] = sel_out ? '0 : JOB_BIN_W'(in_word.bin_select);
      end
      OP_CLEAR: begin
        q_job.kind = JOB_CLEAR;
        q_push     = in_push && !in_full;
      end
      default: ;  // unused code, word dropped
    endcase
  end

endmodule

// ===== src/brh_back.sv =====
module brh_back
  import brh_pkg::*;
#(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  // job queue
  input  logic      q_empty,
  input  job_t      q_job,
  output logic      q_pop,
  // result queue
  input  logic      oq_full,
  output logic      oq_push,
  output out_word_t oq_word,
  // clearing pass after reset
  output logic      init_busy
);

  localparam int BIN_W = $clog2(MAX_BINS);

  logic                   b_valid_r;
  job_kind_t              b_kind_r;
  job_t                   b_job_r;
  logic [BIN_W-1:0]       clr_cnt_r;
  logic                   init_r;
  logic [COUNT_BITS-1:0]  cells_r;
  logic                   b_done;
  logic                   b_adv;

  logic                   we    [COLOURS];
  logic [BIN_W-1:0]       waddr [COLOURS];
  logic [COUNT_BITS-1:0]  wdata [COLOURS];
  logic [BIN_W-1:0]       raddr [COLOURS];
  logic [COUNT_BITS-1:0]  cur   [COLOURS];

  assign init_busy = init_r;

  // completion of the job in the execute stage
  always_comb begin
    b_done = 1'b1;
    case (b_kind_r)
      JOB_ACCUM: b_done = 1'b1;
      JOB_READ:  b_done = !oq_full;
      JOB_CLEAR: b_done = (clr_cnt_r == BIN_W'(MAX_BINS - 1));
      default:   b_done = 1'b1;
    endcase
  end

  assign b_adv = !b_valid_r || b_done;
  assign q_pop = b_adv && !q_empty;

  // write port of each colour store
  always_comb begin
    for (int c = 0; c < COLOURS; c++) begin
      we[c]    = 1'b0;
      waddr[c] = b_job_r.bin[c][BIN_W-1:0];
      wdata[c] = (cur[c] == '1) ? cur[c] : cur[c] + 1'b1;
      raddr[c] = q_job.bin[c][BIN_W-1:0];
      if (b_valid_r) begin
        case (b_kind_r)
          JOB_ACCUM: we[c] = 1'b1;
          JOB_CLEAR: begin
            we[c]    = 1'b1;
            waddr[c] = clr_cnt_r;
            wdata[c] = '0;
          end
          default: ;
        endcase
      end
    end
  end

  // one store per colour: read on issue, write back from execute,
  // with a bypass for the word written at the issue edge
  for (genvar c = 0; c < COLOURS; c++) begin : g_store
    logic [COUNT_BITS-1:0] hist_mem_r [MAX_BINS];
    logic [COUNT_BITS-1:0] rd_data_r;
    logic [COUNT_BITS-1:0] byp_data_r;
    logic                  byp_r;

    always_ff @(posedge clk) begin
      if (we[c]) hist_mem_r[waddr[c]] <= wdata[c];
      if (q_pop) begin
        rd_data_r  <= hist_mem_r[raddr[c]];
        byp_r      <= we[c] && (waddr[c] == raddr[c]);
        byp_data_r <= wdata[c];
      end
    end

    assign cur[c] = byp_r ? byp_data_r : rd_data_r;
  end

  // execute stage control; reset starts a clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b1;
      b_kind_r  <= JOB_CLEAR;
      clr_cnt_r <= '0;
      init_r    <= 1'b1;
      cells_r   <= '0;
    end else begin
      if (b_adv) begin
        b_valid_r <= q_pop;
        if (q_pop) b_kind_r <= q_job.kind;
      end
      if (b_valid_r && b_kind_r == JOB_CLEAR) begin
        clr_cnt_r <= b_done ? '0 : clr_cnt_r + 1'b1;
        cells_r   <= '0;
        if (b_done) init_r <= 1'b0;
      end
      if (b_valid_r && b_kind_r == JOB_ACCUM && cells_r != '1)
        cells_r <= cells_r + 1'b1;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (q_pop) b_job_r <= q_job;
  end

  // read result
  assign oq_push = b_valid_r && (b_kind_r == JOB_READ) && !oq_full;

  always_comb begin
    oq_word            = '0;
    oq_word.bin_number = b_job_r.sel;
    oq_word.cell_total = CNT_W'(cells_r);
    if (!b_job_r.rd_zero) begin
      oq_word.red_count     = CNT_W'(cur[COL_RED]);
      oq_word.green_r_count = CNT_W'(cur[COL_GREEN_R]);
      oq_word.green_b_count = CNT_W'(cur[COL_GREEN_B]);
      oq_word.blue_count    = CNT_W'(cur[COL_BLUE]);
    end
  end

endmodule

// ===== src/bayer_raw_histogram.sv =====
// Channel  Direction  Handshake          Word
// in_      in         in_push / in_full   in_word_t: opcode, four planes, bin select
// out_     out        out_pop / out_empty out_word_t: bin, four counts, cell total
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// Accumulate and read words sustain one per cycle while in_full is low; a read result
// passes the job queue and the execute stage before it is written to the result queue.
// Each colour store does one read-modify-write per cell on a single read and a
// single write port.
// A clear walks all MAX_BINS rows, one row of all four stores a cycle.
// After reset the same walk runs with in_full high.
// A full result queue holds a read in execute and backs up the job queue.
module bayer_raw_histogram
  import brh_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  in_word_t              in_word,
  output logic                  in_full,
  input  logic                  out_pop,
  output out_word_t             out_word,
  output logic                  out_empty
);

  logic      q_push;
  job_t      q_wjob;
  logic      q_full;
  logic      q_pop;
  job_t      q_rjob;
  logic      q_empty;
  logic      oq_push;
  out_word_t oq_word;
  logic      oq_full;
  logic      init_busy;

  // front: configuration and classification
  brh_front #(
    .MAX_BINS    (MAX_BINS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_word   (in_word),
    .in_full   (in_full),
    .q_full    (q_full),
    .back_busy (init_busy),
    .q_push    (q_push),
    .q_job     (q_wjob)
  );

  // jobs between front and back
  brh_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (job_t)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rjob),
    .empty (q_empty)
  );

  // back: histogram stores
  brh_back #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_rjob),
    .q_pop     (q_pop),
    .oq_full   (oq_full),
    .oq_push   (oq_push),
    .oq_word   (oq_word),
    .init_busy (init_busy)
  );

  // results waiting to be taken
  brh_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (out_word_t)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_word),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_word),
    .empty (out_empty)
  );

endmodule
